>>> src/cordic_home_bearing_distance_assert.svh
// assertion macros shared by the checker
`ifndef CORDIC_HOME_BEARING_DISTANCE_ASSERT_SVH
`define CORDIC_HOME_BEARING_DISTANCE_ASSERT_SVH

// same-cycle implication
`define CHBD_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHBD_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/chbd_pkg.sv
`default_nettype none

package chbd_pkg;

  localparam int unsigned MAX_STEPS = 6;
  localparam int unsigned DW        = 32;
  localparam int unsigned ROT_W     = 10;
  localparam int unsigned RTH_W     = 19;
  localparam int unsigned VTH_W     = 20;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned IN_W      = 128;
  localparam int unsigned OUT_W     = 40;
  localparam int unsigned BRG_W     = 9;
  localparam int unsigned DIST_W    = 24;

  localparam logic [ANG_W-1:0] STEP_ANGLE [MAX_STEPS] = '{
    16'd46080, 16'd27203, 16'd14373, 16'd7296, 16'd3662, 16'd1832
  };

  localparam logic [ROT_W-1:0]        ROT_X0       = 10'd64;
  localparam logic [7:0]              LAT_SCALE    = 8'd215;
  localparam logic [6:0]              COS_GAIN     = 7'd39;
  localparam logic [DW-1:0]           LON_HALF     = 32'd1800000000;
  localparam logic [DW-1:0]           LON_FULL     = 32'd3600000000;
  localparam logic signed [VTH_W-1:0] QUARTER_TURN = 20'sd92160;
  localparam logic signed [VTH_W-1:0] FULL_TURN    = 20'sd368640;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [RTH_W-1:0] theta;
  } rot_t;

  typedef struct packed {
    logic signed [DW-1:0]    x;
    logic signed [DW-1:0]    y;
    logic signed [VTH_W-1:0] theta;
  } vec_t;

endpackage

`default_nettype wire

>>> src/chbd_rot_cell.sv
`default_nettype none

module chbd_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire chbd_pkg::rot_t                      rot_i,
  input  wire logic signed [chbd_pkg::RTH_W-1:0]   target_i,
  output chbd_pkg::rot_t                           rot_o
);

  localparam logic signed [chbd_pkg::RTH_W-1:0] ANG =
    chbd_pkg::RTH_W'(chbd_pkg::STEP_ANGLE[STEP]);

  chbd_pkg::rot_t rot_d, rot_q;

  always_comb begin
    if (rot_i.theta < target_i) begin
      rot_d.x     = rot_i.x - (rot_i.y >>> STEP);
      rot_d.y     = rot_i.y + (rot_i.x >>> STEP);
      rot_d.theta = rot_i.theta + ANG;
    end else begin
      rot_d.x     = rot_i.x + (rot_i.y >>> STEP);
      rot_d.y     = rot_i.y - (rot_i.x >>> STEP);
      rot_d.theta = rot_i.theta - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

`default_nettype wire

>>> src/chbd_vec_cell.sv
`default_nettype none

module chbd_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire chbd_pkg::vec_t  vec_i,
  output chbd_pkg::vec_t       vec_o
);

  localparam logic signed [chbd_pkg::VTH_W-1:0] ANG =
    chbd_pkg::VTH_W'(chbd_pkg::STEP_ANGLE[STEP]);

  chbd_pkg::vec_t vec_d, vec_q;
  logic signed [chbd_pkg::DW-1:0] neg_y;

  always_comb begin
    neg_y = -vec_i.y;
    if (vec_i.y[chbd_pkg::DW-1]) begin
      vec_d.x     = vec_i.x + (neg_y >>> STEP);
      vec_d.y     = vec_i.y + (vec_i.x >>> STEP);
      vec_d.theta = vec_i.theta + ANG;
    end else begin
      vec_d.x     = vec_i.x + (vec_i.y >>> STEP);
      vec_d.y     = vec_i.y - (vec_i.x >>> STEP);
      vec_d.theta = vec_i.theta - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

>>> src/cordic_home_bearing_distance.sv
// Home bearing and distance from coordinate differences.
// Input stream s_axis: one item per transfer carrying lat_diff, ref_latitude,
// lon_a and lon_b in degE7. Output stream m_axis: one item per input item,
// bearing_deg (0..359, clockwise from north) and distance_m, in input order.
// Datapath: a row of cells, one cordic step per cell. Longitude wrap, then a
// rotation chain for cos(ref_latitude), gain and scale multiply, quadrant
// pre-rotation, a vectoring chain, and the output register.
// Every stage, from the input register to the output register, is registered.
// Throughput: one item per cycle while m_axis does not stall.
// Stall: each stage holds while its successor is full and stalled; empty
// stages still fill, so input is taken while a result waits on m_axis.
// s_axis_tready drops only once every stage holds an item.
// Reset: rst_ni clears all stage valid bits; nothing is in flight afterwards.
`default_nettype none

module cordic_home_bearing_distance #(
  parameter int unsigned CORDIC_STEPS = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // lat_diff[31:0], ref_latitude[62:32], lon_a[94:63], lon_b[126:95], zero
  input  wire logic [chbd_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // bearing_deg[8:0], distance_m[32:9], zero
  output logic [chbd_pkg::OUT_W-1:0]         m_axis_tdata
);

  localparam int unsigned S      = CORDIC_STEPS;
  localparam int unsigned N      = 2 * S + 5;
  localparam int unsigned S_GAIN = S + 1;
  localparam int unsigned S_MUL  = S + 2;
  localparam int unsigned S_PRE  = S + 3;
  localparam int unsigned S_OUT  = 2 * S + 4;
  localparam int unsigned DW     = chbd_pkg::DW;
  localparam int unsigned ROT_W  = chbd_pkg::ROT_W;
  localparam int unsigned RTH_W  = chbd_pkg::RTH_W;
  localparam int unsigned VTH_W  = chbd_pkg::VTH_W;

  // stage valid and load enables
  logic [N-1:0] v_q;
  logic [N:0]   ld;

  assign ld[N] = m_axis_tready;
  for (genvar k = 0; k < N; k++) begin : g_ld
    assign ld[k] = ~v_q[k] | ld[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < N; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = v_q[N-1];

  // input fields
  logic [DW-1:0] in_lat_diff, in_lon_a, in_lon_b;
  logic [30:0]   in_ref_lat;

  assign in_lat_diff = s_axis_tdata[31:0];
  assign in_ref_lat  = s_axis_tdata[62:32];
  assign in_lon_a    = s_axis_tdata[94:63];
  assign in_lon_b    = s_axis_tdata[126:95];

  // stage 0: magnitudes and rotation target
  logic [DW-1:0]          abs_a_d, abs_b_d;
  logic [30:0]            lat_abs;
  logic [17:0]            tgt_prod;
  logic [DW-1:0]          abs_a_q, abs_b_q, diff_q;
  logic                   same_q, a_neg_q;
  logic [DW-1:0]          lat_p [S_MUL+1];
  logic signed [RTH_W-1:0] tgt_p [S];

  assign abs_a_d  = in_lon_a[DW-1] ? -in_lon_a : in_lon_a;
  assign abs_b_d  = in_lon_b[DW-1] ? -in_lon_b : in_lon_b;
  assign lat_abs  = in_ref_lat[30] ? -in_ref_lat : in_ref_lat;
  assign tgt_prod = lat_abs[30:21] * chbd_pkg::LAT_SCALE;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      abs_a_q  <= abs_a_d;
      abs_b_q  <= abs_b_d;
      diff_q   <= in_lon_a - in_lon_b;
      same_q   <= ~(in_lon_a[DW-1] ^ in_lon_b[DW-1]);
      a_neg_q  <= in_lon_a[DW-1];
    end
  end

  // stage 1: shortest longitude difference
  logic [DW-1:0] lon_sum, lon_m, lon_neg_m, lon_wrap_pos, lon_wrap_neg, dlon_d;
  logic          lon_wrap;
  logic [DW-1:0] lon_p [1:S_GAIN];

  always_comb begin
    lon_sum      = abs_a_q + abs_b_q;
    lon_wrap     = lon_sum > chbd_pkg::LON_HALF;
    lon_m        = lon_sum;
    lon_neg_m    = -lon_sum;
    lon_wrap_pos = chbd_pkg::LON_FULL - lon_sum;
    lon_wrap_neg = lon_sum - chbd_pkg::LON_FULL;
    if (same_q) begin
      dlon_d = diff_q;
    end else if (lon_wrap) begin
      dlon_d = a_neg_q ? lon_wrap_pos : lon_wrap_neg;
    end else begin
      dlon_d = a_neg_q ? lon_neg_m : lon_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      lat_p[0] <= in_lat_diff;
      tgt_p[0] <= signed'({1'b0, tgt_prod});
    end
    if (ld[1]) begin
      lon_p[1] <= dlon_d;
    end
    for (int k = 2; k <= S_GAIN; k++) begin
      if (ld[k]) begin
        lon_p[k] <= lon_p[k-1];
      end
    end
    for (int k = 1; k <= S_MUL; k++) begin
      if (ld[k]) begin
        lat_p[k] <= lat_p[k-1];
      end
    end
    for (int k = 1; k < S; k++) begin
      if (ld[k]) begin
        tgt_p[k] <= tgt_p[k-1];
      end
    end
  end

  // rotation chain for the cosine
  wire chbd_pkg::rot_t rot_s [S+1];

  assign rot_s[0] = '{x: chbd_pkg::ROT_X0, y: '0, theta: '0};

  for (genvar k = 0; k < S; k++) begin : g_rot
    chbd_rot_cell #(
      .STEP (k)
    ) u_rot (
      .clk_i    (clk_i),
      .en_i     (ld[k+1]),
      .rot_i    (rot_s[k]),
      .target_i (tgt_p[k]),
      .rot_o    (rot_s[k+1])
    );
  end

  // gain correction
  logic signed [15:0]      gain_mul;
  logic signed [ROT_W-1:0] xg_q;

  assign gain_mul = 16'(rot_s[S].x) * signed'({1'b0, chbd_pkg::COS_GAIN});

  always_ff @(posedge clk_i) begin
    if (ld[S_GAIN]) begin
      xg_q <= ROT_W'(gain_mul >>> 6);
    end
  end

  // longitude scale multiply
  logic [DW-1:0] lon_g, lon_abs, xg_ext, prod_q;
  logic          dneg_q;

  assign lon_g   = lon_p[S_GAIN];
  assign lon_abs = lon_g[DW-1] ? -lon_g : lon_g;
  assign xg_ext  = {{(DW-ROT_W){xg_q[ROT_W-1]}}, xg_q};

  always_ff @(posedge clk_i) begin
    if (ld[S_MUL]) begin
      prod_q <= (lon_abs >> 4) * xg_ext;
      dneg_q <= lon_g[DW-1];
    end
  end

  // east component and quadrant pre-rotation
  logic [DW-1:0]   scl_m, scl_neg_m, pre_x, pre_y, pre_ny;
  chbd_pkg::vec_t  vec0_d, vec0_q;

  always_comb begin
    scl_m     = prod_q >> 2;
    scl_neg_m = -scl_m;
    pre_x     = lat_p[S_MUL];
    pre_y     = dneg_q ? scl_m : scl_neg_m;
    pre_ny    = dneg_q ? scl_neg_m : scl_m;
    if (pre_x[DW-1] && pre_y[DW-1]) begin
      vec0_d.x     = pre_ny;
      vec0_d.y     = pre_x;
      vec0_d.theta = chbd_pkg::QUARTER_TURN;
    end else if (pre_x[DW-1]) begin
      vec0_d.x     = pre_y;
      vec0_d.y     = -pre_x;
      vec0_d.theta = -chbd_pkg::QUARTER_TURN;
    end else begin
      vec0_d.x     = pre_x;
      vec0_d.y     = pre_y;
      vec0_d.theta = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_PRE]) begin
      vec0_q <= vec0_d;
    end
  end

  // vectoring chain
  wire chbd_pkg::vec_t vec_s [S+1];

  assign vec_s[0] = vec0_q;

  for (genvar k = 0; k < S; k++) begin : g_vec
    chbd_vec_cell #(
      .STEP (k)
    ) u_vec (
      .clk_i (clk_i),
      .en_i  (ld[S_PRE+1+k]),
      .vec_i (vec_s[k]),
      .vec_o (vec_s[k+1])
    );
  end

  // output register
  logic [DW-1:0]                   vx, vx_abs, vx_q4, vx_m7;
  logic signed [VTH_W-1:0]         th, th_fix;
  logic [chbd_pkg::BRG_W-1:0]      bearing_q;
  logic [chbd_pkg::DIST_W-1:0]     dist_q;

  always_comb begin
    vx     = vec_s[S].x;
    vx_abs = vx[DW-1] ? -vx : vx;
    vx_q4  = {2'b00, vx_abs[DW-1:2]};
    vx_m7  = (vx_q4 << 3) - vx_q4;
    th     = vec_s[S].theta;
    th_fix = th[VTH_W-1] ? th + chbd_pkg::FULL_TURN : th;
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_OUT]) begin
      bearing_q <= th_fix[18:10];
      dist_q    <= vx_m7[31:8];
    end
  end

  assign m_axis_tdata = {
    (chbd_pkg::OUT_W - chbd_pkg::DIST_W - chbd_pkg::BRG_W)'(0), dist_q, bearing_q
  };

endmodule

`default_nettype wire

>>> src/chbd_checker.sv
`default_nettype none
`include "cordic_home_bearing_distance_assert.svh"

module chbd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [chbd_pkg::IN_W-1:0]  s_axis_tdata,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [chbd_pkg::OUT_W-1:0] m_axis_tdata
);

  // no item can come out right after reset
  `CHBD_ASSERT_IMP(a_no_out_after_reset, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid,
                   "output valid right after reset")

  // an empty or draining output never blocks the input
  `CHBD_ASSERT_IMP(a_ready_when_draining, clk_i, rst_ni,
                   !m_axis_tvalid || m_axis_tready, s_axis_tready,
                   "input blocked while output drains")

  // bearing stays within a full turn
  `CHBD_ASSERT_IMP(a_bearing_range, clk_i, rst_ni, m_axis_tvalid,
                   m_axis_tdata[8:0] < 9'd360, "bearing out of range")

  // stalled result holds
  `CHBD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // waiting input item holds
  `CHBD_ASSERT_NXT(a_in_hold, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready,
                   s_axis_tvalid && $stable(s_axis_tdata), "waiting input changed")

endmodule

bind cordic_home_bearing_distance chbd_checker u_chbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
